### sv/lifo_stack_with_membership_top_assert.svh
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_MEMBERSHIP_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_MEMBERSHIP_TOP_ASSERT_SVH

// same-cycle implication
`define LSWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lswm_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack package
// Operation codes, sequencer states, result flags and fixed field widths.
// ----------------------------------------------------------------------------
package lswm_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_BITS        = 2;
  localparam int IN_VALUE_BITS  = 32;
  localparam int OUT_VALUE_BITS = 32;
  localparam int COUNT_OUT_BITS = 7;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH        = 2'd0,
    OP_PUSH_UNIQUE = 2'd1,
    OP_POP         = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic found;
    logic pushed;
    logic underflow;
    logic overflow;
  } flags_t;

endpackage

### sv/lswm_if.sv
// ----------------------------------------------------------------------------
// LIFO stack channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface lswm_in_if;
  import lswm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_BITS-1:0]       operation;
  logic [IN_VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface lswm_out_if;
  import lswm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OUT_VALUE_BITS-1:0] popped_value;
  logic                      found;
  logic                      pushed;
  logic                      underflow_error;
  logic                      overflow_error;
  logic [COUNT_OUT_BITS-1:0] entry_count;
  logic                      empty_res;

  modport source (output valid, output popped_value, output found, output pushed,
                  output underflow_error, output overflow_error, output entry_count,
                  output empty_res, input ready);
  modport sink   (input valid, input popped_value, input found, input pushed,
                  input underflow_error, input overflow_error, input entry_count,
                  input empty_res, output ready);
endinterface

### sv/lswm_mem.sv
// ----------------------------------------------------------------------------
// LIFO stack entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lswm_mem #(
  parameter int DEPTH      = lswm_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lswm_pkg::VALUE_BITS_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/lswm_ctrl.sv
// ----------------------------------------------------------------------------
// LIFO stack sequencer
// Runs push, pop and top-down search one entry per cycle through a single
// comparator, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module lswm_ctrl #(
  parameter int DEPTH      = lswm_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lswm_pkg::VALUE_BITS_DEF,
  parameter int AW         = $clog2(DEPTH),
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lswm_pkg::op_t         in_op,
  input  logic [VALUE_BITS-1:0] in_val,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_popped,
  output lswm_pkg::flags_t      out_flags,
  output logic [CNT_W-1:0]      out_count,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [VALUE_BITS-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [VALUE_BITS-1:0] rd_data
);
  import lswm_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  op_t                   op_r, op_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  flags_t                flags_r, flags_nxt;
  logic [VALUE_BITS-1:0] pop_r, pop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_pop_r, out_pop_nxt;
  flags_t                out_flags_r, out_flags_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic             full;
  logic             empty;
  logic             hit;
  logic             out_free;
  logic             accept;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign hit      = (rd_data == val_r);
  assign out_free = !out_valid_r || out_ready;
  assign accept   = (state_r == ST_IDLE) && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op) inside
            OP_PUSH: state_nxt = ST_DONE;
            OP_POP:  state_nxt = empty ? ST_DONE : ST_POP_WAIT;
            OP_PUSH_UNIQUE, OP_QUERY: state_nxt = empty ? ST_DONE : ST_SCAN;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_POP_WAIT: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (hit || idx_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    rd_en         = 1'b0;
    rd_addr       = cnt_m1[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = (state_r == ST_IDLE) ? in_val : val_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    flags_nxt     = flags_r;
    pop_nxt       = pop_r;
    out_valid_nxt = out_valid_r;
    out_pop_nxt   = out_pop_r;
    out_flags_nxt = out_flags_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          val_nxt   = in_val;
          flags_nxt = '0;
          pop_nxt   = '0;
          idx_nxt   = cnt_m1[AW-1:0];
          unique case (in_op) inside
            OP_PUSH: begin
              if (full) begin
                flags_nxt.overflow = 1'b1;
              end else begin
                wr_en            = 1'b1;
                cnt_nxt          = cnt_r + CNT_W'(1);
                flags_nxt.pushed = 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                flags_nxt.underflow = 1'b1;
              end else begin
                rd_en   = 1'b1;
                cnt_nxt = cnt_m1;
              end
            end
            OP_PUSH_UNIQUE, OP_QUERY: begin
              if (!empty) begin
                rd_en = 1'b1;
              end else if (in_op == OP_PUSH_UNIQUE) begin
                // empty stack is never full
                wr_en            = 1'b1;
                cnt_nxt          = cnt_r + CNT_W'(1);
                flags_nxt.pushed = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP_WAIT: begin
        pop_nxt = rd_data;
      end
      ST_SCAN: begin
        if (hit) begin
          flags_nxt.found = 1'b1;
        end else if (idx_r == '0) begin
          // searched down to the bottom without a match
          if (op_r == OP_PUSH_UNIQUE) begin
            if (full) begin
              flags_nxt.overflow = 1'b1;
            end else begin
              wr_en            = 1'b1;
              cnt_nxt          = cnt_r + CNT_W'(1);
              flags_nxt.pushed = 1'b1;
            end
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pop_nxt   = pop_r;
          out_flags_nxt = flags_r;
          out_cnt_nxt   = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    flags_r     <= flags_nxt;
    pop_r       <= pop_nxt;
    out_pop_r   <= out_pop_nxt;
    out_flags_r <= out_flags_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_popped = out_pop_r;
  assign out_flags  = out_flags_r;
  assign out_count  = out_cnt_r;

`include "lifo_stack_with_membership_top_assert.svh"

  `LSWM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "occupancy above depth")
  `LSWM_ASSERT_NOW(a_no_write_full, wr_en, !full, "write issued on a full stack")
  `LSWM_ASSERT_NEXT(a_pop_step, accept && in_op == OP_POP && !empty,
    state_r == ST_POP_WAIT && cnt_r == $past(cnt_r) - CNT_W'(1), "pop did not drop the top")
  `LSWM_ASSERT_NOW(a_flags_excl, state_r == ST_DONE,
    !(flags_r.pushed && (flags_r.overflow || flags_r.found)), "conflicting result flags")

endmodule

### sv/lifo_stack_with_membership_top.sv
// ----------------------------------------------------------------------------
// LIFO stack with membership search
// Bounded stack of value words with push, unique push, pop and query.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_ch.ready is high only while the block is
// idle. A push, a pop of an empty stack, and a query or unique push on an empty
// stack go from idle straight to the done state; a pop passes through a read
// wait state, and a query or unique push on a non-empty stack through the scan
// state, where a single comparator walks the entry memory from the top down,
// one registered read per cycle, until a match or the bottom entry. The result
// reaches the output register at the edge where the block returns to idle.
// A finished result waits in the output register while the next beat is
// accepted; if an earlier result still sits there untaken, the block holds the
// new one and stays busy until the output register frees up. Entries need no
// clearing after reset: only entries below the occupancy count are ever read.
module lifo_stack_with_membership_top #(
  parameter int DEPTH      = lswm_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lswm_pkg::VALUE_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  lswm_in_if.sink      in_ch,
  lswm_out_if.source   out_ch
);
  import lswm_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_BITS+IN_VALUE_BITS-1:0]  in_ext;
  logic [VALUE_BITS-1:0]                in_val;
  logic [VALUE_BITS-1:0]                out_popped;
  logic [VALUE_BITS+OUT_VALUE_BITS-1:0] pop_ext;
  flags_t                               out_flags;
  logic [CNT_W-1:0]                     out_count;
  logic [CNT_W+COUNT_OUT_BITS-1:0]      cnt_ext;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  // keep only the low VALUE_BITS of the input word
  assign in_ext  = {{VALUE_BITS{1'b0}}, in_ch.value};
  assign in_val  = in_ext[VALUE_BITS-1:0];
  assign pop_ext = {{OUT_VALUE_BITS{1'b0}}, out_popped};
  assign cnt_ext = {{COUNT_OUT_BITS{1'b0}}, out_count};

  lswm_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (op_t'(in_ch.operation)),
    .in_val     (in_val),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_popped (out_popped),
    .out_flags  (out_flags),
    .out_count  (out_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  lswm_mem #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ch.popped_value    = pop_ext[OUT_VALUE_BITS-1:0];
  assign out_ch.found           = out_flags.found;
  assign out_ch.pushed          = out_flags.pushed;
  assign out_ch.underflow_error = out_flags.underflow;
  assign out_ch.overflow_error  = out_flags.overflow;
  assign out_ch.entry_count     = cnt_ext[COUNT_OUT_BITS-1:0];
  assign out_ch.empty_res       = (out_count == '0);

endmodule

### bench/lifo_stack_with_membership_top_test.sv
// ----------------------------------------------------------------------------
// LIFO stack with membership search: block-level test
// Drives push, unique push, pop and query beats with random gaps and stalls,
// predicts every result from a shadow stack and checks each result beat field
// by field, in order. Random traffic drains, fills and overflows the stack.
// ----------------------------------------------------------------------------
module lifo_stack_with_membership_top_test;
  import lswm_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int RANDOM_OPS  = 900;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } stack_op_t;

  typedef struct packed {
    logic [31:0] popped;
    logic        found;
    logic        pushed;
    logic        underflow;
    logic        overflow;
    logic [6:0]  count;
    logic        empty;
  } stack_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lswm_in_if  in_ch ();
  lswm_out_if out_ch ();

  lifo_stack_with_membership_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow stack
  logic [31:0]   shadow_mem [STACK_DEPTH];
  int            shadow_fill = 0;

  stack_op_t     op_backlog[$];
  stack_result_t pending_results[$];
  logic [31:0]   seen_vals[$];

  stack_op_t     tx_item;
  int            tx_wait = 0;
  bit            tx_calm = 1'b0;
  int            rx_wait = 0;
  bit            rx_calm = 1'b0;
  logic          rx_hold = 1'b0;
  logic          in_took = 1'b0;
  logic          out_took = 1'b0;

  int            mismatches = 0;
  int            ops_taken = 0;
  int            results_seen = 0;
  int            n_found = 0;
  int            n_overflow = 0;
  int            n_underflow = 0;
  int            peak_fill = 0;

  function automatic bit shadow_holds(logic [31:0] val);
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_mem[i] == val) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit shadow_write(logic [31:0] val);
    if (shadow_fill >= STACK_DEPTH) return 1'b0;
    shadow_mem[shadow_fill] = val;
    shadow_fill++;
    return 1'b1;
  endfunction

  function automatic stack_result_t stack_apply(op_t op, logic [31:0] val);
    stack_result_t r;
    r = '0;
    case (op)
      OP_PUSH: begin
        r.pushed   = shadow_write(val);
        r.overflow = !r.pushed;
      end
      OP_PUSH_UNIQUE: begin
        r.found = shadow_holds(val);
        if (!r.found) begin
          r.pushed   = shadow_write(val);
          r.overflow = !r.pushed;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.underflow = 1'b1;
        end else begin
          shadow_fill--;
          r.popped = shadow_mem[shadow_fill];
        end
      end
      default: begin
        r.found = shadow_holds(val);
      end
    endcase
    r.count = 7'(shadow_fill);
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    stack_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("beat with nothing expected, popped_value", out_ch.popped_value, '0);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.popped_value !== want.popped)
      report_mismatch("popped_value", out_ch.popped_value, want.popped);
    if (out_ch.found !== want.found)
      report_mismatch("found", 32'(out_ch.found), 32'(want.found));
    if (out_ch.pushed !== want.pushed)
      report_mismatch("pushed", 32'(out_ch.pushed), 32'(want.pushed));
    if (out_ch.underflow_error !== want.underflow)
      report_mismatch("underflow_error", 32'(out_ch.underflow_error), 32'(want.underflow));
    if (out_ch.overflow_error !== want.overflow)
      report_mismatch("overflow_error", 32'(out_ch.overflow_error), 32'(want.overflow));
    if (out_ch.entry_count !== want.count)
      report_mismatch("entry_count", 32'(out_ch.entry_count), 32'(want.count));
    if (out_ch.empty_res !== want.empty)
      report_mismatch("empty_res", 32'(out_ch.empty_res), 32'(want.empty));
    if (want.found) n_found++;
    if (want.overflow) n_overflow++;
    if (want.underflow) n_underflow++;
  endtask

  // sample both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_ch.valid && in_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(stack_apply(op_t'(in_ch.operation), in_ch.value));
        ops_taken++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // operation driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_took)) begin
      if (in_took) begin
        if ($urandom_range(29) == 0) tx_calm = !tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (tx_wait > 0 || op_backlog.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (tx_wait > 0) tx_wait--;
      end else begin
        tx_item = op_backlog.pop_front();
        in_ch.operation <= tx_item.op;
        in_ch.value     <= tx_item.value;
        in_ch.valid     <= 1'b1;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(29) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hold off the receiver for a long stretch so the block backs up
  initial begin
    wait (ops_taken >= 400);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (250) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    if (pick < 6 && seen_vals.size() != 0)
      return seen_vals[$urandom_range(seen_vals.size() - 1)];
    return $urandom;
  endfunction

  task automatic queue_op(op_t op, logic [31:0] val);
    stack_op_t item;
    item.op    = op;
    item.value = val;
    op_backlog.push_back(item);
    if (op == OP_PUSH || op == OP_PUSH_UNIQUE) begin
      seen_vals.push_back(val);
      if (seen_vals.size() > 24) void'(seen_vals.pop_front());
    end
  endtask

  initial begin
    int directed_n;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;

    // directed: empty-stack cases, extremes, duplicates, searches down to the bottom
    queue_op(OP_POP,         32'h1234_5678);
    queue_op(OP_QUERY,       32'h0000_0000);
    queue_op(OP_PUSH_UNIQUE, 32'h0000_0000);
    queue_op(OP_PUSH,        32'hFFFF_FFFF);
    queue_op(OP_PUSH,        32'h0000_0000);
    queue_op(OP_PUSH_UNIQUE, 32'hFFFF_FFFF);
    queue_op(OP_PUSH_UNIQUE, 32'h0000_0001);
    queue_op(OP_QUERY,       32'h0000_0000);
    queue_op(OP_QUERY,       32'hFFFF_FFFF);
    queue_op(OP_QUERY,       32'h8000_0000);
    queue_op(OP_PUSH,        32'hA5A5_5A5A);
    queue_op(OP_POP,         32'h0000_0000);
    queue_op(OP_POP,         32'hFFFF_FFFF);
    queue_op(OP_POP,         32'h0000_0000);
    queue_op(OP_POP,         32'h0000_0000);
    queue_op(OP_POP,         32'h0000_0000);
    queue_op(OP_POP,         32'h0000_0000);
    queue_op(OP_QUERY,       32'hFFFF_FFFF);
    queue_op(OP_PUSH_UNIQUE, 32'h5555_AAAA);
    queue_op(OP_POP,         32'hFFFF_FFFF);
    directed_n = op_backlog.size();

    // random: drain, fill to the top, hit the full-stack cases, then mix
    while (op_backlog.size() < directed_n + RANDOM_OPS) begin
      repeat ($urandom_range(66, 70)) queue_op(OP_POP, $urandom);
      repeat (STACK_DEPTH) begin
        if ($urandom_range(3) == 0) queue_op(OP_PUSH_UNIQUE, $urandom);
        else queue_op(OP_PUSH, pick_value());
      end
      queue_op(OP_PUSH, pick_value());
      queue_op(OP_PUSH_UNIQUE, seen_vals[$]);
      queue_op(OP_PUSH_UNIQUE, $urandom);
      queue_op(OP_QUERY, pick_value());
      repeat ($urandom_range(80, 120)) queue_op(op_t'($urandom_range(3)), pick_value());
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    $display("summary: %0d operations, %0d results; %0d found, %0d dropped on full",
             ops_taken, results_seen, n_found, n_overflow);
    $display("summary: %0d pops on empty, peak occupancy %0d of %0d",
             n_underflow, peak_fill, STACK_DEPTH);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
